FILE: rtl/fewd_pkg.sv
// Shared types and constants for the frame energy wake detector.
// Used by fewd_ctrl, fewd_dp and frame_energy_wake_detector; no dependencies.
package fewd_pkg;

    // Frame bound, data widths and the widths derived from the bound
    localparam int MAX_FRAME_SAMPLES = 1024;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 31;
    localparam int MEAN_W    = 31;
    localparam int CNT_W     = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W     = SQ_W + $clog2(MAX_FRAME_SAMPLES);
    localparam int STEP_W    = $clog2(SUM_W + 1);
    localparam int THR_W     = 16;
    localparam int THR_SQ_W  = 2 * THR_W;
    localparam int RUN_W     = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED  = 1'd1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd3000;
    localparam logic [RUN_W-1:0] REQUIRED_RESET  = 8'd3;

    typedef enum logic [2:0] {
        S_ACC,
        S_FLUSH,
        S_LOAD,
        S_DIV,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept_en;
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_last;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/frame_energy_wake_detector.sv
// Frame energy wake detector: top level joining controller and datapath.
// Depends on fewd_pkg, fewd_ctrl and fewd_dp.
//
// Samples are taken one per cycle while a frame accumulates. After the beat
// that carries frame_end the input stays stalled while the last square
// reaches the sum, the divider is loaded, the restoring divider produces one
// quotient bit per cycle over the 41-bit sum, and loud and wake are decided;
// the stall lasts longer if the previous result is still waiting at the output.
// A frame result sits in an output register, so the next frame's samples
// are taken while it waits. Configuration writes are always ready.
module frame_energy_wake_detector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fewd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fewd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [fewd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_frame_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_wake,
    output logic                                 o_loud,
    output logic [fewd_pkg::MEAN_W-1:0]          o_avg_power,
    output logic                                 o_frame_too_long
);

    fewd_pkg::t_cmd    w_cmd;
    fewd_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_cmd.accept_en;

    fewd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    fewd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_sample         (i_sample),
        .i_frame_end      (i_frame_end),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_wake           (o_wake),
        .o_loud           (o_loud),
        .o_avg_power      (o_avg_power),
        .o_frame_too_long (o_frame_too_long)
    );

    // A frame-end beat closes the input until its result is built
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_frame_end |=> o_in_stall)
        else $error("input open right after a frame-end beat");

    // An over-long frame is never loud
    a_long_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_loud && o_frame_too_long))
        else $error("over-long frame marked loud");

    // Wake only comes with a loud frame
    a_wake_loud: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wake |-> o_loud)
        else $error("wake without a loud frame");

    // Mean square never exceeds the largest sample square
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_avg_power <= 31'h4000_0000)
        else $error("mean square out of range");

endmodule

FILE: rtl/fewd_ctrl.sv
// Controller for the frame energy wake detector: sequences accumulation,
// the bit-serial division and the frame result. Depends on fewd_pkg.
module fewd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fewd_pkg::t_status i_status,
    output fewd_pkg::t_cmd    o_cmd
);

    fewd_pkg::t_state r_state, n_state;
    logic [fewd_pkg::STEP_W-1:0] r_step, n_step;

    // State and step counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fewd_pkg::S_ACC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            fewd_pkg::S_ACC: begin
                o_cmd.accept_en = 1'b1;
                if (i_status.in_last) begin
                    n_state = fewd_pkg::S_FLUSH;
                end
            end
            fewd_pkg::S_FLUSH: begin
                // let the last square land in the sum
                n_state = fewd_pkg::S_LOAD;
            end
            fewd_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = fewd_pkg::S_DIV;
            end
            fewd_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == fewd_pkg::STEP_W'(fewd_pkg::SUM_W - 1)) begin
                    n_state = fewd_pkg::S_FIN;
                end
            end
            fewd_pkg::S_FIN: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = fewd_pkg::S_ACC;
                end
            end
            default: begin
                n_state = fewd_pkg::S_ACC;
            end
        endcase
    end

endmodule

FILE: rtl/fewd_dp.sv
// Datapath for the frame energy wake detector: configuration registers,
// square accumulation, restoring divider, loud-run counter, output register.
// Depends on fewd_pkg.
module fewd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fewd_pkg::t_cmd                    i_cmd,
    output fewd_pkg::t_status                 o_status,
    input  logic                              i_cfg_valid,
    input  logic [fewd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fewd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic signed [fewd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_frame_end,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic                              o_wake,
    output logic                              o_loud,
    output logic [fewd_pkg::MEAN_W-1:0]       o_avg_power,
    output logic                              o_frame_too_long
);

    logic [fewd_pkg::THR_W-1:0]    r_thr;
    logic [fewd_pkg::RUN_W-1:0]    r_req;
    logic [fewd_pkg::THR_SQ_W-1:0] r_thr_sq;

    logic                          r_sq_vld;
    logic [fewd_pkg::SQ_W-1:0]     r_sq;
    logic [fewd_pkg::SUM_W-1:0]    r_sum;
    logic [fewd_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_overflow;

    logic [fewd_pkg::SUM_W-1:0]    r_quo;
    logic [fewd_pkg::CNT_W-1:0]    r_rem;
    logic [fewd_pkg::CNT_W-1:0]    r_div;
    logic                          r_too_long;

    logic [fewd_pkg::RUN_W-1:0]    r_run;

    logic                          r_out_vld;
    logic                          r_wake;
    logic                          r_loud;
    logic [fewd_pkg::MEAN_W-1:0]   r_mean;
    logic                          r_out_long;

    logic                          w_in_fire;
    logic [fewd_pkg::MAG_W-1:0]    w_mag;
    logic [2*fewd_pkg::MAG_W-1:0]  w_prod;
    logic [fewd_pkg::CNT_W:0]      w_rem_sh;
    logic                          w_ge;
    logic [fewd_pkg::CNT_W:0]      w_rem_nx;
    logic [fewd_pkg::MEAN_W-1:0]   w_mean;
    logic                          w_loud;
    logic [fewd_pkg::RUN_W-1:0]    w_need;
    logic [fewd_pkg::RUN_W-1:0]    w_run_inc;
    logic                          w_wake;

    assign w_in_fire = i_in_valid && i_cmd.accept_en;

    // Magnitude of the sample; the most negative value maps to 0x8000
    assign w_mag  = i_sample[fewd_pkg::SAMPLE_W-1] ? fewd_pkg::MAG_W'(-i_sample)
                                                   : fewd_pkg::MAG_W'(i_sample);
    assign w_prod = w_mag * w_mag;

    // One restoring division step per cycle while the step command is high
    assign w_rem_sh = {r_rem, r_quo[fewd_pkg::SUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;

    // Frame decision from the finished quotient
    assign w_mean    = r_too_long ? '0 : r_quo[fewd_pkg::MEAN_W-1:0];
    assign w_loud    = !r_too_long && ({1'b0, w_mean} >= r_thr_sq);
    assign w_need    = (r_req == '0) ? fewd_pkg::RUN_W'(1) : r_req;
    assign w_run_inc = (r_run == '1) ? r_run : r_run + 1'b1;
    assign w_wake    = w_loud && (w_run_inc >= w_need);

    assign o_status.in_last  = w_in_fire && i_frame_end;
    assign o_status.out_free = !r_out_vld || !i_out_stall;

    // Configuration registers and the registered threshold square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= fewd_pkg::THRESHOLD_RESET;
            r_req <= fewd_pkg::REQUIRED_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fewd_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data;
                fewd_pkg::CFG_REQUIRED:  r_req <= i_cfg_data[fewd_pkg::RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_sq <= r_thr * r_thr;
    end

    // Square stage and frame accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld   <= 1'b0;
            r_sum      <= '0;
            r_cnt      <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_sq_vld <= 1'b0;
            if (w_in_fire && !r_overflow) begin
                if (r_cnt >= fewd_pkg::CNT_W'(fewd_pkg::MAX_FRAME_SAMPLES)) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_cnt    <= r_cnt + 1'b1;
                    r_sq_vld <= 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_sum      <= '0;
                r_cnt      <= '0;
                r_overflow <= 1'b0;
            end else if (r_sq_vld) begin
                r_sum <= r_sum + fewd_pkg::SUM_W'(r_sq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_sq <= w_prod[fewd_pkg::SQ_W-1:0];
        end
    end

    // Divider: load the frame totals, then shift one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo      <= r_sum;
            r_rem      <= '0;
            r_div      <= r_cnt;
            r_too_long <= r_overflow;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[fewd_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_rem_nx[fewd_pkg::CNT_W-1:0];
        end
    end

    // Loud-run counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
                if (w_loud && !w_wake) begin
                    r_run <= w_run_inc;
                end else begin
                    r_run <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_wake     <= w_wake;
            r_loud     <= w_loud;
            r_mean     <= w_mean;
            r_out_long <= r_too_long;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_wake           = r_wake;
    assign o_loud           = r_loud;
    assign o_avg_power      = r_mean;
    assign o_frame_too_long = r_out_long;

endmodule

FILE: verif/tb_frame_energy_wake_detector.sv
// Self-checking testbench for frame_energy_wake_detector: directed and random frames,
// with a scoreboard that predicts each frame verdict and checks it against the output.
// Depends on fewd_pkg and the frame_energy_wake_detector RTL.
module tb_frame_energy_wake_detector;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 2 * (fewd_pkg::SUM_W + 3);
    localparam int LONG_HOLD      = 400;
    localparam int RUN_LIMIT      = 8_000_000;

    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;

    // One frame verdict as the block reports it
    typedef struct packed {
        logic                        wake;
        logic                        loud;
        logic [fewd_pkg::MEAN_W-1:0] avg_power;
        logic                        too_long;
    } t_frame_verdict;

    // Tracks frame energy and the loud run; queues the verdict of each frame end
    class t_wake_scoreboard;
        logic [fewd_pkg::THR_W-1:0] threshold;
        logic [7:0]                 required;
        logic [fewd_pkg::SUM_W-1:0] energy;
        int unsigned                count;
        bit                         overflow;
        logic [7:0]                 loud_run;
        t_frame_verdict             pending_verdicts[$];
        int                         errors;
        int                         n_samples, n_frames, n_wake, n_loud, n_long, n_writes;

        function new();
            threshold = fewd_pkg::THRESHOLD_RESET;
            required  = fewd_pkg::REQUIRED_RESET;
            energy    = '0;
            count     = 0;
            overflow  = 1'b0;
            loud_run  = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [fewd_pkg::CFG_IDX_W-1:0] idx,
                                logic [fewd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                fewd_pkg::CFG_THRESHOLD: threshold = data[fewd_pkg::THR_W-1:0];
                fewd_pkg::CFG_REQUIRED:  required  = data[7:0];
                default: ;
            endcase
            n_writes++;
        endfunction

        // Advance the frame state by one accepted beat
        function void take_sample(logic signed [15:0] s, logic fe);
            longint               mag;
            logic [fewd_pkg::SUM_W-1:0] mean;
            longint               thr_sq;
            logic [7:0]           need;
            t_frame_verdict       v;
            n_samples++;
            if (!overflow) begin
                if (count >= fewd_pkg::MAX_FRAME_SAMPLES) begin
                    overflow = 1'b1;
                end else begin
                    mag = s;
                    if (mag < 0) mag = -mag;
                    energy += fewd_pkg::SUM_W'(mag * mag);
                    count++;
                end
            end
            if (!fe) return;

            v = '0;
            v.too_long = overflow;
            mean = '0;
            if (!overflow && count != 0) begin
                mean   = energy / fewd_pkg::SUM_W'(count);
                thr_sq = longint'(threshold) * longint'(threshold);
                v.loud = longint'(mean) >= thr_sq;
            end
            v.avg_power = mean[fewd_pkg::MEAN_W-1:0];

            // Required frames of zero counts as one
            need = (required == 0) ? 8'd1 : required;
            if (v.loud) begin
                if (loud_run != 8'd255) loud_run++;
                if (loud_run >= need) begin
                    v.wake   = 1'b1;
                    loud_run = '0;
                end
            end else begin
                loud_run = '0;
            end

            energy   = '0;
            count    = 0;
            overflow = 1'b0;
            n_frames++;
            n_wake += v.wake;
            n_loud += v.loud;
            n_long += v.too_long;
            pending_verdicts.push_back(v);
        endfunction

        function void compare_field(string name, longint exp_val, longint act_val);
            if (exp_val != act_val) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_verdict(t_frame_verdict act);
            t_frame_verdict exp_v;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %s",
                         $time, "beat");
                $display("    wake=%0b loud=%0b power=%0d long=%0b",
                         act.wake, act.loud, act.avg_power, act.too_long);
                errors++;
                return;
            end
            exp_v = pending_verdicts.pop_front();
            compare_field("wake", exp_v.wake, act.wake);
            compare_field("loud", exp_v.loud, act.loud);
            compare_field("avg_power", exp_v.avg_power, act.avg_power);
            compare_field("frame_too_long", exp_v.too_long, act.too_long);
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function void report_leftover();
            if (pending_verdicts.size() != 0) begin
                $display("%0t: missing results: expected %0d more, actual 0",
                         $time, pending_verdicts.size());
                errors++;
            end
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [fewd_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [fewd_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic signed [fewd_pkg::SAMPLE_W-1:0] i_sample = '0;
    logic                                 i_frame_end = 1'b0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic                                 o_wake;
    logic                                 o_loud;
    logic [fewd_pkg::MEAN_W-1:0]          o_avg_power;
    logic                                 o_frame_too_long;

    t_wake_scoreboard sb = new();
    bit gaps_on   = 1'b1;
    bit long_hold = 1'b0;

    frame_energy_wake_detector dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .i_frame_end      (i_frame_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_wake           (o_wake),
        .o_loud           (o_loud),
        .o_avg_power      (o_avg_power),
        .o_frame_too_long (o_frame_too_long)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Drop the run if it hangs
    initial begin
        #RUN_LIMIT;
        $display("*** FAILED ***");
        $finish;
    end

    // Check every beat the block hands out
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_verdict('{o_wake, o_loud, o_avg_power, o_frame_too_long});
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
                i_out_stall <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // Write both registers back to back
    task automatic write_config(input int unsigned thr, input int unsigned req);
        logic [fewd_pkg::CFG_DATA_W-1:0] req_word;
        req_word = {8'($urandom), 8'(req)};
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fewd_pkg::CFG_THRESHOLD;
        i_cfg_data  <= 16'(thr);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(fewd_pkg::CFG_THRESHOLD, 16'(thr));
        i_cfg_index <= fewd_pkg::CFG_REQUIRED;
        i_cfg_data  <= req_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(fewd_pkg::CFG_REQUIRED, req_word);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one sample beat, with an optional idle burst ahead of it
    task automatic push_sample(input logic signed [15:0] s, input logic fe, input bit bursty);
        if (bursty && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample    <= s;
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_sample(s, fe);
    endtask

    // Hold the input idle until every frame verdict is out and the block is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Pick a sample: quiet, near threshold, full range or an extreme
    function automatic logic signed [15:0] draw_sample(int level, int unsigned thr);
        int unsigned lo, hi, mag;
        int          val;
        case (level)
            0: mag = $urandom_range(0, 255);
            1: begin
                lo = (thr * 3) / 4;
                hi = (thr * 3) / 2 + 8;
                if (hi > 32768) hi = 32768;
                if (lo > hi) lo = hi;
                mag = $urandom_range(lo, hi);
            end
            2: return 16'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0: return SAMPLE_MIN;
                    1: return SAMPLE_MAX;
                    2: return -SAMPLE_MAX;
                    3: return 16'sd0;
                    default: return ($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1;
                endcase
            end
        endcase
        if (mag >= 32768) val = -32768;
        else val = ($urandom_range(0, 1) != 0) ? -int'(mag) : int'(mag);
        return 16'(val);
    endfunction

    task automatic send_frame(input int len, input int unsigned thr);
        int pick, level;
        bit bursty;
        pick   = $urandom_range(0, 19);
        level  = (pick < 12) ? 1 : (pick < 15) ? 0 : (pick < 18) ? 2 : 3;
        bursty = gaps_on && ($urandom_range(0, 2) != 0);
        for (int k = 0; k < len; k++) begin
            push_sample(draw_sample(level, thr), k == len - 1, bursty);
        end
    endtask

    // One setting, then random frames of up to max_len samples
    task automatic run_phase(input int unsigned thr, input int unsigned req,
                             input int n_items, input int max_len, input bit hold);
        int sent, len;
        write_config(thr, req);
        if (hold) long_hold = 1'b1;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, max_len);
            send_frame(len, thr);
            sent += len;
        end
        settle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: extremes, exact threshold, floor of the mean
        push_sample(SAMPLE_MIN, 1'b1, gaps_on);
        push_sample(SAMPLE_MAX, 1'b1, gaps_on);
        push_sample(16'sd3000, 1'b1, gaps_on);
        push_sample(16'sd2999, 1'b1, gaps_on);
        push_sample(16'sd0, 1'b0, gaps_on);
        push_sample(16'sd0, 1'b1, gaps_on);
        push_sample(16'sd3000, 1'b0, gaps_on);
        push_sample(-16'sd3000, 1'b0, gaps_on);
        push_sample(16'sd2999, 1'b1, gaps_on);
        push_sample(SAMPLE_MAX, 1'b0, gaps_on);
        push_sample(SAMPLE_MIN, 1'b0, gaps_on);
        push_sample(16'sd1, 1'b0, gaps_on);
        push_sample(-16'sd1, 1'b1, gaps_on);
        settle();

        // Zero threshold makes every frame loud; zero required acts as one
        write_config(0, 0);
        push_sample(16'sd0, 1'b1, gaps_on);
        push_sample(16'sd0, 1'b1, gaps_on);
        settle();

        // Threshold beyond the sample range: never loud
        write_config(16'hffff, 1);
        push_sample(SAMPLE_MIN, 1'b1, gaps_on);
        push_sample(SAMPLE_MAX, 1'b0, gaps_on);
        push_sample(SAMPLE_MAX, 1'b1, gaps_on);
        settle();

        // Full-scale threshold: only the negative extreme reaches it
        write_config(32768, 2);
        push_sample(SAMPLE_MIN, 1'b1, gaps_on);
        push_sample(SAMPLE_MIN, 1'b1, gaps_on);
        push_sample(SAMPLE_MAX, 1'b1, gaps_on);
        settle();

        // Frame-length bound: one sample too many, then a short frame after it
        write_config(32768, 1);
        for (int k = 0; k <= fewd_pkg::MAX_FRAME_SAMPLES; k++) begin
            push_sample(16'($urandom), k == fewd_pkg::MAX_FRAME_SAMPLES, gaps_on);
        end
        push_sample(SAMPLE_MIN, 1'b1, gaps_on);
        settle();

        // Random frames under a spread of settings
        run_phase(3000, 3, 36, 12, 1'b1);
        run_phase(0, 1, 14, 6, 1'b0);
        run_phase(16'hffff, 2, 10, 8, 1'b0);
        run_phase(32768, 1, 10, 4, 1'b0);
        run_phase(1, 0, 14, 6, 1'b0);
        run_phase(0, 255, 16, 1, 1'b0);
        repeat (4) begin
            run_phase($urandom_range(0, 12000), $urandom_range(1, 5), 10, 8, 1'b0);
        end
        gaps_on = 1'b0;
        run_phase($urandom_range(500, 6000), $urandom_range(1, 4), 24, 10, 1'b0);

        sb.report_leftover();
        $display("Run covered %0d samples in %0d frames over %0d register writes.",
                 sb.n_samples, sb.n_frames, sb.n_writes);
        $display("Verdicts seen: %0d loud, %0d wake, %0d over-length frames; %0d mismatches.",
                 sb.n_loud, sb.n_wake, sb.n_long, sb.errors);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/fewd_pkg.sv
rtl/fewd_ctrl.sv
rtl/fewd_dp.sv
rtl/frame_energy_wake_detector.sv
verif/tb_frame_energy_wake_detector.sv
